// ----- rtl/core/double_ended_queue_defines.svh -----
// Assertion macros shared by the deque RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ----- rtl/core/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// No dependencies.
package deq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_ACCEPT = 2'b01,
        FSM_READ   = 2'b10
    } fsm_state_t;

    // Decision of the pointer unit for the operation on the input port
    typedef struct packed {
        status_t status;
        logic    wr_issue;
        logic    rd_issue;
    } deq_resp_t;

endpackage

// ----- rtl/core/deq_ram.sv -----
// Single-port slot store with registered read data.
// Uses deq_pkg for the data width.
module deq_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic                               rd_en,
    input  logic [IDX_W-1:0]                   addr,
    input  logic signed [deq_pkg::DATA_W-1:0]  wr_data,
    output logic signed [deq_pkg::DATA_W-1:0]  rd_data
);

    logic signed [deq_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [deq_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/deq_ptr.sv -----
// Head, tail and count registers of the deque; decodes each operation.
// Uses deq_pkg and the assertion macros in double_ended_queue_defines.svh.
`include "double_ended_queue_defines.svh"

module deq_ptr #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4,
    parameter int unsigned CNT_W = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          take,
    input  logic [deq_pkg::OP_W-1:0]      opcode,
    output deq_pkg::deq_resp_t            resp,
    output logic [IDX_W-1:0]              mem_addr,
    output logic [CNT_W-1:0]              count_after
);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] head_prev, head_succ, tail_prev, tail_succ;
    logic             full, empty;
    logic             push_take;

    // ring wrap in both directions; DEPTH need not be a power of two
    assign head_prev = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_succ = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_prev = (tail_reg == '0) ? IDX_W'(DEPTH - 1) : tail_reg - 1'b1;
    assign tail_succ = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        mem_addr      = head_reg;
        resp.status   = deq_pkg::ST_OK;
        resp.wr_issue = 1'b0;
        resp.rd_issue = 1'b0;
        unique case (deq_pkg::opcode_t'(opcode))
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    resp.status = deq_pkg::ST_FULL;
                end else begin
                    resp.wr_issue = 1'b1;
                    mem_addr      = head_prev;
                    head_next     = head_prev;
                    count_next    = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    resp.status = deq_pkg::ST_FULL;
                end else begin
                    resp.wr_issue = 1'b1;
                    mem_addr      = tail_reg;
                    tail_next     = tail_succ;
                    count_next    = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    resp.status = deq_pkg::ST_EMPTY;
                end else begin
                    resp.rd_issue = 1'b1;
                    mem_addr      = head_reg;
                    head_next     = head_succ;
                    count_next    = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    resp.status = deq_pkg::ST_EMPTY;
                end else begin
                    resp.rd_issue = 1'b1;
                    mem_addr      = tail_prev;
                    tail_next     = tail_prev;
                    count_next    = count_reg - 1'b1;
                end
            end
            default: begin
                resp.status = deq_pkg::ST_OK;
            end
        endcase
    end

    assign count_after = count_next;
    assign push_take   = take && resp.wr_issue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (take) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    `DEQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `DEQ_ASSERT_SAME(a_empty_ptrs, aclk, aresetn, count_reg == '0, head_reg == tail_reg)
    `DEQ_ASSERT_NEXT(a_push_count, aclk, aresetn, push_take, count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- rtl/core/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit values, DEPTH entries deep, held in a
// single-port synchronous RAM addressed as a ring by head and tail pointers with an
// occupancy count. Each input transfer carries an opcode (push front, push back, pop
// front, pop back) and a value; each produces exactly one result transfer holding the
// popped value (zero unless a pop succeeded), a status (ok, pop from empty, push into
// full) and the occupancy after the operation, taken modulo 32. Refused operations
// leave the state untouched. Timing: a push, or any refused operation, posts its result
// into the output register directly from FSM_ACCEPT; a successful pop passes through
// FSM_READ, because the RAM read data is registered and input acceptance pauses while
// in that state. The result sits in an output register, so a new input transfer is taken
// in the same cycle the previous result is taken downstream. No clearing pass is needed
// after reset. Depends on deq_pkg, deq_ptr, deq_ram and double_ended_queue_defines.svh.
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [deq_pkg::OP_W-1:0]           s_opcode,
    input  logic signed [deq_pkg::DATA_W-1:0]  s_push_value,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [deq_pkg::DATA_W-1:0]  m_pop_value,
    output logic [deq_pkg::STAT_W-1:0]         m_status,
    output logic [deq_pkg::OCC_W-1:0]          m_occupancy
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    deq_pkg::fsm_state_t state_reg, state_next;

    logic                              m_valid_reg, m_valid_next;
    logic signed [deq_pkg::DATA_W-1:0] m_pop_value_reg, m_pop_value_next;
    deq_pkg::status_t                  m_status_reg, m_status_next;
    logic [deq_pkg::OCC_W-1:0]         m_occupancy_reg, m_occupancy_next;

    deq_pkg::deq_resp_t                resp;
    logic [IDX_W-1:0]                  mem_addr;
    logic [CNT_W-1:0]                  count_after;
    logic signed [deq_pkg::DATA_W-1:0] rd_data;
    logic                              take;
    logic                              m_stall;

    // Input is taken only when no RAM read is outstanding and the output
    // register is empty or being emptied in this cycle.
    assign s_ready = (state_reg == deq_pkg::FSM_ACCEPT) && (!m_valid_reg || m_ready);
    assign take    = s_valid && s_ready;

    // pointer / count unit: decides the operation and the slot it touches
    deq_ptr #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ptr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .opcode      (s_opcode),
        .resp        (resp),
        .mem_addr    (mem_addr),
        .count_after (count_after)
    );

    // slot store; at most one access per transfer, never a read and a write together
    deq_ram #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (take && resp.wr_issue),
        .rd_en   (take && resp.rd_issue),
        .addr    (mem_addr),
        .wr_data (s_push_value),
        .rd_data (rd_data)
    );

    // Result sequencing. A successful pop parks in FSM_READ for the RAM's
    // read latency; everything else posts its result straight away.
    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        m_pop_value_next = m_pop_value_reg;
        m_status_next    = m_status_reg;
        m_occupancy_next = m_occupancy_reg;
        unique case (state_reg)
            deq_pkg::FSM_ACCEPT: begin
                if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                end
                if (take) begin
                    m_status_next    = resp.status;
                    m_occupancy_next = deq_pkg::OCC_W'(count_after);
                    if (resp.rd_issue) begin
                        state_next = deq_pkg::FSM_READ;
                    end else begin
                        m_valid_next     = 1'b1;
                        m_pop_value_next = '0;
                    end
                end
            end
            deq_pkg::FSM_READ: begin
                // output register is known empty here
                m_pop_value_next = rd_data;
                m_valid_next     = 1'b1;
                state_next       = deq_pkg::FSM_ACCEPT;
            end
            default: begin
                state_next = deq_pkg::FSM_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= deq_pkg::FSM_ACCEPT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        m_pop_value_reg <= m_pop_value_next;
        m_status_reg    <= m_status_next;
        m_occupancy_reg <= m_occupancy_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_pop_value = m_pop_value_reg;
    assign m_status    = m_status_reg;
    assign m_occupancy = m_occupancy_reg;

    // result waiting on the receiver
    assign m_stall = m_valid && !m_ready;

    `DEQ_ASSERT_SAME(a_read_blocks_input, aclk, aresetn, state_reg == deq_pkg::FSM_READ, !s_ready)
    `DEQ_ASSERT_NEXT(a_read_posts_result, aclk, aresetn, state_reg == deq_pkg::FSM_READ, m_valid)
    `DEQ_ASSERT_NEXT(a_result_held, aclk, aresetn, m_stall, m_valid && $stable(m_pop_value))

endmodule
